### sv/mosaic_pixel_sampler_assert.svh
// Assertion macros shared by the mosaic pixel sampler RTL.
// Holds macro definitions only; no other file is required.
`ifndef MOSAIC_PIXEL_SAMPLER_ASSERT_SVH
`define MOSAIC_PIXEL_SAMPLER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MPS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define MPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### sv/mps_pkg.sv
// Package for the mosaic pixel sampler: field widths and shared types.
// Depends on nothing; every other RTL file imports it.
`default_nettype none

package mps_pkg;

   // Widths of the request and response fields.
   localparam int XW = 9;
   localparam int YW = 8;
   localparam int CW = 8;
   localparam int BW = 9;

   // One remainder cell per dividend bit of the wider coordinate.
   localparam int NCELL = XW;

   // Width of the sample coordinate before clamping: origin plus half a block.
   localparam int SW = XW + 1;

   // Width used to compare coordinates against the image limits.
   localparam int LW = 13;

   // Request codes.
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   // Data handed from one remainder cell to the next.
   typedef struct packed {
      logic          valid;
      logic          mode;
      logic [XW-1:0] x;
      logic [YW-1:0] y;
      logic [CW-1:0] color;
      logic [XW-1:0] xs;   // dividend bits still to be shifted in
      logic [XW-1:0] ys;
      logic [BW-1:0] rx;   // partial remainders
      logic [BW-1:0] ry;
   } lane_type;

   // Command to the image store.
   typedef struct packed {
      logic we;
      logic re;
   } mem_cmd_type;

endpackage

`default_nettype wire

### sv/mps_div_cell.sv
// One cell of the remainder chain: takes one dividend bit of each coordinate.
// Depends on mps_pkg.
`default_nettype none

module mps_div_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [mps_pkg::BW-1:0] block,
   input  wire mps_pkg::lane_type      lane_in,
   output mps_pkg::lane_type           lane_out
);
   import mps_pkg::*;

   lane_type      lane_ff;
   lane_type      lane_in_w;
   logic [BW:0]   trial_x;
   logic [BW:0]   trial_y;

   // Restoring step: shift in the next bit, subtract the block size if it fits.
   always_comb begin
      lane_in_w = lane_in;
      trial_x   = {lane_in.rx, lane_in.xs[XW-1]};
      trial_y   = {lane_in.ry, lane_in.ys[XW-1]};
      if (trial_x >= {1'b0, block}) begin
         trial_x = trial_x - {1'b0, block};
      end
      if (trial_y >= {1'b0, block}) begin
         trial_y = trial_y - {1'b0, block};
      end
      lane_in_w.rx = trial_x[BW-1:0];
      lane_in_w.ry = trial_y[BW-1:0];
      lane_in_w.xs = {lane_in.xs[XW-2:0], 1'b0};
      lane_in_w.ys = {lane_in.ys[XW-2:0], 1'b0};
      // Only the valid flag needs a reset.
      if (reset) begin
         lane_in_w.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_in_w;
   end

   assign lane_out = lane_ff;

endmodule

`default_nettype wire

### sv/mps_addr_gen.sv
// Turns a finished remainder lane into a clamped image store address.
// Depends on mps_pkg.
`default_nettype none

module mps_addr_gen #(
   parameter int WIDTH  = 320,
   parameter int HEIGHT = 240,
   parameter int AW     = 17
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [mps_pkg::BW-1:0] block,
   input  wire mps_pkg::lane_type      lane_in,
   output mps_pkg::mem_cmd_type        cmd,
   output logic [AW-1:0]               addr,
   output logic [mps_pkg::CW-1:0]      color
);
   import mps_pkg::*;

   localparam logic [LW-1:0] XMAX = LW'(WIDTH - 1);
   localparam logic [LW-1:0] YMAX = LW'(HEIGHT - 1);
   localparam logic [LW-1:0] XLIM = LW'(WIDTH);
   localparam logic [LW-1:0] YLIM = LW'(HEIGHT);

   // Stage one: sample point, or the raw coordinate on a write.
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_read_ff, s1_read_in;
   logic          s1_wr_ok_ff, s1_wr_ok_in;
   logic [SW-1:0] s1_sx_ff, s1_sx_in;
   logic [SW-1:0] s1_sy_ff, s1_sy_in;
   logic [CW-1:0] s1_color_ff;

   // Stage two: clamped coordinates.
   logic          s2_valid_ff;
   logic          s2_read_ff;
   logic          s2_wr_ok_ff;
   logic [SW-1:0] s2_sx_ff, s2_sx_in;
   logic [SW-1:0] s2_sy_ff, s2_sy_in;
   logic [CW-1:0] s2_color_ff;

   // Stage three: store address and command.
   mem_cmd_type   s3_cmd_ff, s3_cmd_in;
   logic [AW-1:0] s3_addr_ff, s3_addr_in;
   logic [CW-1:0] s3_color_ff;

   logic [XW-1:0] origin_x;
   logic [BW-1:0] origin_y;

   // The block origin is the coordinate minus its remainder.
   always_comb begin
      origin_x    = lane_in.x - lane_in.rx;
      origin_y    = {1'b0, lane_in.y} - lane_in.ry;
      s1_valid_in = lane_in.valid;
      s1_read_in  = (lane_in.mode == MODE_READ);
      s1_wr_ok_in = (LW'(lane_in.x) < XLIM) && (LW'(lane_in.y) < YLIM);
      if (s1_read_in) begin
         s1_sx_in = SW'(origin_x) + SW'(block[BW-1:1]);
         s1_sy_in = SW'(origin_y) + SW'(block[BW-1:1]);
      end else begin
         s1_sx_in = SW'(lane_in.x);
         s1_sy_in = SW'(lane_in.y);
      end
   end

   // Clamp the sample point to the last column and row.
   always_comb begin
      s2_sx_in = (LW'(s1_sx_ff) > XMAX) ? SW'(XMAX) : s1_sx_ff;
      s2_sy_in = (LW'(s1_sy_ff) > YMAX) ? SW'(YMAX) : s1_sy_ff;
   end

   // Row-major address; an out-of-image write is dropped here.
   always_comb begin
      s3_addr_in   = AW'(s2_sy_ff) * AW'(WIDTH) + AW'(s2_sx_ff);
      s3_cmd_in.re = s2_valid_ff && s2_read_ff;
      s3_cmd_in.we = s2_valid_ff && !s2_read_ff && s2_wr_ok_ff;
   end

   always_ff @(posedge clock) begin
      s1_read_ff  <= s1_read_in;
      s1_wr_ok_ff <= s1_wr_ok_in;
      s1_sx_ff    <= s1_sx_in;
      s1_sy_ff    <= s1_sy_in;
      s1_color_ff <= lane_in.color;
      s2_read_ff  <= s1_read_ff;
      s2_wr_ok_ff <= s1_wr_ok_ff;
      s2_sx_ff    <= s2_sx_in;
      s2_sy_ff    <= s2_sy_in;
      s2_color_ff <= s1_color_ff;
      s3_addr_ff  <= s3_addr_in;
      s3_color_ff <= s2_color_ff;
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_cmd_ff   <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_cmd_ff   <= s3_cmd_in;
      end
   end

   assign cmd   = s3_cmd_ff;
   assign addr  = s3_addr_ff;
   assign color = s3_color_ff;

endmodule

`default_nettype wire

### sv/mosaic_pixel_sampler.sv
// Top level of the mosaic pixel sampler: remainder chain, address pipeline
// and image store. Depends on mps_pkg, mps_div_cell, mps_addr_gen and the
// assertion macro header.
//
//   channel  ports                                   handshake
//   -------  --------------------------------------  ------------------------
//   request  req_mode req_pix_x req_pix_y req_src_*   start high, busy low
//   response rsp_out_color                           rsp_valid, one cycle
//   csr      csr_data                                csr_valid and csr_ready
//
// One request is taken every clock while busy is low. A read is answered
// via nine remainder cells (one per coordinate bit), three address stages
// and the registered store read. Writes pass the same pipeline, so every
// access hits the store in request order. After reset busy is high for one
// cycle; the store is not cleared. The receiver cannot stall the response.
`default_nettype none

`include "mosaic_pixel_sampler_assert.svh"

module mosaic_pixel_sampler #(
   parameter int WIDTH  = 320,
   parameter int HEIGHT = 240
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic                   req_mode,
   input  wire logic [mps_pkg::XW-1:0] req_pix_x,
   input  wire logic [mps_pkg::YW-1:0] req_pix_y,
   input  wire logic [mps_pkg::CW-1:0] req_src_color,
   output logic                        rsp_valid,
   output logic [mps_pkg::CW-1:0]      rsp_out_color,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [mps_pkg::BW-1:0] csr_data
);
   import mps_pkg::*;

   localparam int DEPTH = WIDTH * HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int LAT   = NCELL + 4;

   logic          busy_ff;
   logic [BW-1:0] block_ff, block_in;
   lane_type      lanes [NCELL+1];
   mem_cmd_type   cmd;
   logic [AW-1:0] addr;
   logic [CW-1:0] wr_color;
   logic [CW-1:0] mem [DEPTH];
   logic [CW-1:0] rd_ff;
   logic          rsp_valid_ff;
   logic          accept;

   assign accept = start && !busy_ff;

   // Block size register; a size of zero behaves as one.
   assign csr_ready = 1'b1;
   assign block_in  = (csr_data == '0) ? BW'(1) : csr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_ff <= BW'(1);
         busy_ff  <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            block_ff <= block_in;
         end
      end
   end

   // Feed a new request into the first cell.
   always_comb begin
      lanes[0].valid = accept;
      lanes[0].mode  = req_mode;
      lanes[0].x     = req_pix_x;
      lanes[0].y     = req_pix_y;
      lanes[0].color = req_src_color;
      lanes[0].xs    = req_pix_x;
      lanes[0].ys    = {1'b0, req_pix_y};
      lanes[0].rx    = '0;
      lanes[0].ry    = '0;
   end

   // Remainder chain: each cell works one bit of x mod b and y mod b.
   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      mps_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .block    (block_ff),
         .lane_in  (lanes[k]),
         .lane_out (lanes[k+1])
      );
   end

   mps_addr_gen #(
      .WIDTH  (WIDTH),
      .HEIGHT (HEIGHT),
      .AW     (AW)
   ) u_addr (
      .clock   (clock),
      .reset   (reset),
      .block   (block_ff),
      .lane_in (lanes[NCELL]),
      .cmd     (cmd),
      .addr    (addr),
      .color   (wr_color)
   );

   // Image store with a registered read.
   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[addr] <= wr_color;
      end
      if (cmd.re) begin
         rd_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.re;
      end
   end

   assign busy          = busy_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_color = rd_ff;

   // A finished lane carries remainders below the block size if the size did not change on its way.
   `MPS_ASSERT_SAME(a_rem_below_block, clock, reset, lanes[NCELL].valid,
      (lanes[NCELL].rx < block_ff) && (lanes[NCELL].ry < block_ff))
   // An accepted read is answered once it has passed the cells, address stages and store read.
   `MPS_ASSERT_SAME(a_read_answered, clock, reset, accept && req_mode == MODE_READ,
      ##LAT rsp_valid)
   // An accepted write never produces a response.
   `MPS_ASSERT_SAME(a_write_silent, clock, reset, accept && req_mode == MODE_WRITE,
      ##LAT !rsp_valid)
   // The store is never written and read in the same cycle.
   `MPS_ASSERT_SAME(a_one_access, clock, reset, cmd.we, !cmd.re)
   // The response strobe follows exactly the read commands.
   `MPS_ASSERT_NEXT(a_strobe_follows_read, clock, reset, cmd.re, rsp_valid)

endmodule

`default_nettype wire
